FILE: rtl/tlv_record_deframer_defines.svh
// Assertion macros for the record deframer.
// No dependencies; included by the top level, which supplies clk and rst_n.
`ifndef TLV_RECORD_DEFRAMER_DEFINES_SVH
`define TLV_RECORD_DEFRAMER_DEFINES_SVH

// Check a same-cycle implication outside reset.
`define TLVD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, outside reset.
`define TLVD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tlvd_pkg.sv
// Shared types and codes for the record deframer.
// No dependencies; used by tlvd_core and tlv_record_deframer.
`default_nettype none

package tlvd_pkg;

  // Byte role codes
  localparam logic [2:0] ROLE_TYPE_CHAR = 3'd0;
  localparam logic [2:0] ROLE_TYPE_END  = 3'd1;
  localparam logic [2:0] ROLE_LEN_HI    = 3'd2;
  localparam logic [2:0] ROLE_LEN_LO    = 3'd3;
  localparam logic [2:0] ROLE_VALUE     = 3'd4;

  // Container status codes
  localparam logic [1:0] ST_CONTINUE  = 2'd0;
  localparam logic [1:0] ST_ACCEPT    = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  // One tagged byte on the result side
  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  byte_role;
    logic        record_done;
    logic [15:0] value_length;
    logic [1:0]  status;
  } tlvd_result_t;

endpackage

`default_nettype wire

FILE: rtl/tlvd_core.sv
// Record phase tracker: classifies one byte against the current phase.
// Depends on tlvd_pkg; state advances only when the byte moves on.
`default_nettype none

module tlvd_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last,
  output tlvd_pkg::tlvd_result_t  res
);

  // Phase codes
  localparam logic [1:0] PH_TYPE   = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_LEN_LO = 2'd2;
  localparam logic [1:0] PH_VALUE  = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  upper_r, upper_nxt;
  logic [15:0] rem_dec;
  logic [15:0] vlen;

  assign rem_dec = rem_r - 16'd1;
  assign vlen    = {upper_r, data_byte};

  // Classify the byte and work out the next phase
  always_comb begin
    res.byte_value   = data_byte;
    res.byte_role    = tlvd_pkg::ROLE_TYPE_CHAR;
    res.record_done  = 1'b0;
    res.value_length = 16'd0;
    res.status       = tlvd_pkg::ST_CONTINUE;
    phase_nxt        = phase_r;
    rem_nxt          = rem_r;
    upper_nxt        = upper_r;
    case (phase_r)
      PH_LEN_HI: begin
        res.byte_role = tlvd_pkg::ROLE_LEN_HI;
        upper_nxt     = data_byte;
        phase_nxt     = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        res.byte_role    = tlvd_pkg::ROLE_LEN_LO;
        res.value_length = vlen;
        if (vlen == 16'd0) begin
          res.record_done = 1'b1;
          phase_nxt       = PH_TYPE;
        end else begin
          rem_nxt   = vlen;
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        res.byte_role = tlvd_pkg::ROLE_VALUE;
        rem_nxt       = rem_dec;
        if (rem_dec == 16'd0) begin
          res.record_done = 1'b1;
          phase_nxt       = PH_TYPE;
        end
      end
      default: begin
        if (data_byte == 8'd0) begin
          res.byte_role = tlvd_pkg::ROLE_TYPE_END;
          phase_nxt     = PH_LEN_HI;
        end else begin
          res.byte_role = tlvd_pkg::ROLE_TYPE_CHAR;
          phase_nxt     = PH_TYPE;
        end
      end
    endcase
    // Close the container on its last byte and return to the start phase
    if (last) begin
      res.status = res.record_done ? tlvd_pkg::ST_ACCEPT : tlvd_pkg::ST_TRUNCATED;
      phase_nxt  = PH_TYPE;
      rem_nxt    = 16'd0;
      upper_nxt  = 8'd0;
    end
  end

  // Advance the phase state when a byte is handed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      rem_r   <= 16'd0;
      upper_r <= 8'd0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      upper_r <= upper_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tlv_record_deframer.sv
// Type-length-value record deframer: one tagged result per container byte.
// Each request passes an input register, the phase logic in tlvd_core and a
// result register. One byte is accepted every cycle while the output is not
// stalled; the phase update in tlvd_core sets that rate. Every byte is tagged
// with its role, the length low byte carries the decoded value length, and the
// last byte of a container reports accepted or truncated before the parser
// returns to the type phase. Depends on tlvd_pkg, tlvd_core and
// tlv_record_deframer_defines.svh.
`default_nettype none
`include "tlv_record_deframer_defines.svh"

module tlv_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte_value,
  output logic [2:0]       out_byte_role,
  output logic             out_record_done,
  output logic [15:0]      out_value_length,
  output logic [1:0]       out_status
);

  logic                   s1_v_r;
  logic [7:0]             s1_byte_r;
  logic                   s1_last_r;
  logic                   s2_v_r;
  tlvd_pkg::tlvd_result_t s2_res_r;
  tlvd_pkg::tlvd_result_t core_res;
  logic                   s2_free;
  logic                   adv;
  logic                   in_take;

  assign s2_free  = !s2_v_r || !out_stall;
  assign adv      = s1_v_r && s2_free;
  assign in_stall = s1_v_r && !s2_free;
  assign in_take  = in_valid && !in_stall;

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_take) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last;
    end
  end

  tlvd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .data_byte (s1_byte_r),
    .last      (s1_last_r),
    .res       (core_res)
  );

  // Register the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= 1'b1;
    end else if (!out_stall) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_res_r <= core_res;
    end
  end

  assign out_valid        = s2_v_r;
  assign out_byte_value   = s2_res_r.byte_value;
  assign out_byte_role    = s2_res_r.byte_role;
  assign out_record_done  = s2_res_r.record_done;
  assign out_value_length = s2_res_r.value_length;
  assign out_status       = s2_res_r.status;

  // Consistency checks
  `TLVD_ASSERT_NOW(a_done_role, out_valid && out_record_done,
    (out_byte_role == tlvd_pkg::ROLE_LEN_LO) || (out_byte_role == tlvd_pkg::ROLE_VALUE),
    "record end on a byte that cannot close a record")
  `TLVD_ASSERT_NOW(a_accept_done, out_valid && (out_status == tlvd_pkg::ST_ACCEPT),
    out_record_done, "container accepted mid-record")
  `TLVD_ASSERT_NOW(a_len_role, out_valid && (out_value_length != 16'd0),
    out_byte_role == tlvd_pkg::ROLE_LEN_LO, "value length shown outside the length low byte")
  `TLVD_ASSERT_NEXT(a_stall_holds, in_stall, s1_v_r, "input register emptied while stalled")

endmodule

`default_nettype wire
